>>> sv/mssw_pkg.sv
// ----------------------------------------------------------------------------
// mssw_pkg: shared types and constants of the multi-slot stopwatch timer
// Item codes, unit codes, the queued command record and queue status.
// ----------------------------------------------------------------------------
package mssw_pkg;

    localparam int COUNT_W     = 48;
    localparam int ACTION_W    = 2;
    localparam int SLOT_W      = 8;
    localparam int UNIT_W      = 2;
    localparam int DIV_W       = 20;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [UNIT_W-1:0]   t_unit;

    localparam t_action ACT_TICK    = 2'd0;
    localparam t_action ACT_START   = 2'd1;
    localparam t_action ACT_READ    = 2'd2;
    localparam t_action ACT_RESTART = 2'd3;

    // codes two and three both select seconds
    localparam t_unit UNIT_US = 2'd0;
    localparam t_unit UNIT_MS = 2'd1;

    localparam logic [DIV_W-1:0] US_PER_MS = 20'd1000;
    localparam logic [DIV_W-1:0] US_PER_S  = 20'd1000000;

    // scaling by reciprocal: q = (x * ceil(2^k / d)) >> k, exact for any
    // 48-bit x; the product is built from 24-bit limbs of x
    localparam int RECIP_W  = 49;
    localparam int LIMB_W   = 24;
    localparam int PROD_W   = COUNT_W + RECIP_W;
    localparam int SHIFT_MS = 58;
    localparam int SHIFT_S  = 68;
    localparam logic [RECIP_W-1:0] RECIP_MS = 49'd288230376151712;
    localparam logic [RECIP_W-1:0] RECIP_S  = 49'd295147905179353;

    // table command with the count snapshot taken when the item was accepted
    typedef struct packed {
        t_action              action;
        logic [SLOT_W-1:0]    slot;
        t_unit                unit;
        logic [COUNT_W-1:0]   stamp;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> sv/mssw_front.sv
// ----------------------------------------------------------------------------
// mssw_front: input side of the stopwatch timer
// Keeps the free-running count, absorbs tick items and forwards table items.
// ----------------------------------------------------------------------------
module mssw_front #(
    parameter int LOW_COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  mssw_pkg::t_action         i_action,
    input  logic [mssw_pkg::SLOT_W-1:0] i_slot,
    input  mssw_pkg::t_unit           i_unit,
    input  mssw_pkg::t_q_stat         i_q_stat,
    output logic                      o_push,
    output mssw_pkg::t_cmd            o_cmd
);
    import mssw_pkg::*;

    localparam int HIGH_W = COUNT_W - LOW_COUNT_BITS;

    logic [LOW_COUNT_BITS-1:0] r_low;
    logic [LOW_COUNT_BITS-1:0] n_low;
    logic [HIGH_W-1:0]         r_high;
    logic [HIGH_W-1:0]         n_high;
    logic                      tick;

    // ticks never wait; table items wait for queue space
    assign o_ready = (i_action == ACT_TICK) || !i_q_stat.full;
    assign tick    = i_valid && o_ready && (i_action == ACT_TICK);
    assign o_push  = i_valid && o_ready && (i_action != ACT_TICK);

    // advance the low field, carry into the overflow count on wrap
    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        if (tick) begin
            n_low = LOW_COUNT_BITS'(r_low + 1'b1);
            if (&r_low) begin
                n_high = HIGH_W'(r_high + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    // attach the current count to the item
    always_comb begin
        o_cmd.action = i_action;
        o_cmd.slot   = i_slot;
        o_cmd.unit   = i_unit;
        o_cmd.stamp  = {r_high, r_low};
    end

endmodule

>>> sv/mssw_queue.sv
// ----------------------------------------------------------------------------
// mssw_queue: short command queue between front and back
// Register-based FIFO of table commands.
// ----------------------------------------------------------------------------
module mssw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mssw_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output mssw_pkg::t_cmd    o_cmd,
    output mssw_pkg::t_q_stat o_stat
);
    import mssw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;

    assign o_stat.full  = (r_fill == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    // store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= (PTR_W+1)'(r_fill + 1'b1);
                2'b01:   r_fill <= (PTR_W+1)'(r_fill - 1'b1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> sv/mssw_back.sv
// ----------------------------------------------------------------------------
// mssw_back: execution side of the stopwatch timer
// Holds the start table, forms elapsed time, scales it and drives the result.
// ----------------------------------------------------------------------------
module mssw_back #(
    parameter int NUM_SLOTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mssw_pkg::t_cmd               i_cmd,
    input  mssw_pkg::t_q_stat            i_q_stat,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mssw_pkg::COUNT_W-1:0] o_elapsed
);
    import mssw_pkg::*;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] LAST_STEP = 2'd3;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(NUM_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } t_bstate;

    t_bstate            r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic               r_ok, n_ok;
    logic [COUNT_W-1:0] r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_slot_vld;
    logic [COUNT_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [COUNT_W-1:0] r_opnd, n_opnd;
    logic [PROD_W-1:0]  r_acc, n_acc;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_data, n_out_data;

    logic                      ok_in;
    logic [IDX_W-1:0]          idx_in;
    logic                      we;
    logic [COUNT_W-1:0]        start_val;
    logic [COUNT_W-1:0]        elapsed;
    logic [RECIP_W-1:0]        recip;
    logic [LIMB_W-1:0]         mul_a;
    logic [RECIP_W-LIMB_W-1:0] mul_b;
    logic [RECIP_W-1:0]        prod;
    logic [PROD_W-1:0]         addend;
    logic [COUNT_W-1:0]        scaled;

    assign o_pop   = (r_state == S_IDLE) && !i_q_stat.empty;
    assign ok_in   = ({1'b0, i_cmd.slot} < SLOT_LIMIT);
    assign idx_in  = i_cmd.slot[IDX_W-1:0];
    assign we      = o_pop && ok_in &&
                     ((i_cmd.action == ACT_START) || (i_cmd.action == ACT_RESTART));

    assign o_valid   = r_out_valid;
    assign o_elapsed = r_out_data;

    // start table: read-first, so a restart sees the old start
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[idx_in] <= i_cmd.stamp;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[idx_in];
            r_rd_vld  <= r_slot_vld[idx_in];
        end
    end

    // mark written entries; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (we) begin
            r_slot_vld[idx_in] <= 1'b1;
        end
    end

    assign start_val = r_rd_vld ? r_rd_data : '0;
    assign elapsed   = COUNT_W'(r_cmd.stamp - start_val);

    // one partial product per step: bit 1 picks the limb of the elapsed
    // time, bit 0 the limb of the reciprocal
    assign recip = (r_cmd.unit == UNIT_MS) ? RECIP_MS : RECIP_S;
    assign mul_a = r_step[1] ? r_opnd[COUNT_W-1:LIMB_W] : r_opnd[LIMB_W-1:0];
    assign mul_b = r_step[0] ? recip[RECIP_W-1:LIMB_W]
                             : (RECIP_W-LIMB_W)'(recip[LIMB_W-1:0]);
    assign prod  = RECIP_W'(mul_a) * RECIP_W'(mul_b);

    // align the partial product by the weight of its two limbs
    always_comb begin
        addend = PROD_W'(prod);
        if (&r_step) begin
            addend = {prod, {COUNT_W{1'b0}}};
        end else if (r_step[0] ^ r_step[1]) begin
            addend = PROD_W'({prod, {LIMB_W{1'b0}}});
        end
    end

    assign scaled = (r_cmd.unit == UNIT_MS) ? COUNT_W'(r_acc[PROD_W-1:SHIFT_MS])
                                            : COUNT_W'(r_acc[PROD_W-1:SHIFT_S]);

    // sequence lookup, four multiply steps for a scaled read, and result hand-off
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ok        = r_ok;
        n_opnd      = r_opnd;
        n_acc       = r_acc;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_cmd;
                    n_ok  = ok_in;
                    if (i_cmd.action != ACT_START) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_opnd  = r_ok ? elapsed : '0;
                n_acc   = '0;
                n_step  = '0;
                n_state = (r_cmd.unit == UNIT_US) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                n_acc  = r_acc + addend;
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_cmd.unit == UNIT_US) ? r_opnd : scaled;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ok       <= n_ok;
        r_opnd     <= n_opnd;
        r_acc      <= n_acc;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

    a_mul_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_step != LAST_STEP) |=> (r_state == S_MUL))
        else $error("multiply left before its last step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_ready) |=>
        (r_state == S_DONE && r_out_valid))
        else $error("finished result dropped while output stalled");

    a_look_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !o_pop) |=> (r_state == S_IDLE))
        else $error("lookup started without a queued command");

    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_slot_vld[$past(idx_in)])
        else $error("written slot not marked valid");

endmodule

>>> sv/multi_slot_stopwatch_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_stopwatch_timer: 48-bit microsecond count with stopwatch slots
// Top level joining the front, the command queue and the back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one item of i_action, i_slot and
//   i_unit. A tick item advances the count and is taken in every cycle, even
//   while the queue is full. Start, read and restart items capture the count
//   and wait in a four-entry queue; o_ready drops for them when it is full.
//   Output channel (o_valid/i_ready) gives o_elapsed for read and restart.
//   A microsecond read goes from the lookup straight to the result stage; a
//   millisecond or second read first runs the four multiply steps of the
//   reciprocal scaling in the back. The back serves one table item at a
//   time and takes the next from the queue only when it is idle again.
//   Slots outside the table read as zero.
//   Reset clears the count, the queue and the slot valid bits, so every slot
//   starts at zero with no clearing pass. When the receiver stalls, the
//   result holds in the output register; the back finishes the next item and
//   waits, and ticks keep being accepted.
// ----------------------------------------------------------------------------
module multi_slot_stopwatch_timer #(
    parameter int NUM_SLOTS      = 256,
    parameter int LOW_COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  mssw_pkg::t_action            i_action,
    input  logic [mssw_pkg::SLOT_W-1:0]  i_slot,
    input  mssw_pkg::t_unit              i_unit,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mssw_pkg::COUNT_W-1:0] o_elapsed
);
    import mssw_pkg::*;

    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // accept items and keep the count
    mssw_front #(
        .LOW_COUNT_BITS(LOW_COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_slot   (i_slot),
        .i_unit   (i_unit),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // buffer table commands
    mssw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // execute table commands
    mssw_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_elapsed (o_elapsed)
    );

endmodule
